// ----- sv/skt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Request codes, result codes, controller states and the command/status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int SKT_CAPACITY = 16;
    localparam logic signed [31:0] SKT_RESERVED_RESET = 32'sh8000_0000;

    typedef enum logic [2:0] {
        FN_INSERT        = 3'd0,
        FN_INSERT_UNIQUE = 3'd1,
        FN_INDEX_OF      = 3'd2,
        FN_COUNT         = 3'd3,
        FN_REMOVE        = 3'd4,
        FN_GET           = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISS     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_FULL     = 3'd3,
        ST_RESERVED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_END,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_FETCH_RD,
        S_FETCH_EV,
        S_REM_RD,
        S_REM_WR,
        S_RESP
    } state_t;

    // read address relative to the index register
    typedef enum logic [1:0] {
        RD_AT_IDX,
        RD_BELOW,
        RD_ABOVE
    } rd_sel_t;

    typedef struct packed {
        logic    load_req;
        logic    idx_clear;
        logic    idx_load_pos;
        logic    idx_load_fill;
        logic    idx_inc;
        logic    idx_dec;
        logic    mark_load;
        logic    hit_clear;
        logic    hit_load;
        logic    cnt_clear;
        logic    cnt_inc;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_key;
        logic    fill_inc;
        logic    fill_dec;
        logic    fetch_load;
        logic    out_load;
        status_t status;
    } skt_cmd_t;

    typedef struct packed {
        func_t func;
        logic  key_reserved;
        logic  idx_at_fill;
        logic  idx_at_mark;
        logic  idx_last;
        logic  pos_in_range;
        logic  full;
        logic  rd_less;
        logic  rd_equal;
        logic  hit;
        logic  out_busy;
    } skt_stat_t;

endpackage
`default_nettype wire

// ----- sv/sorted_key_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table: ordered table of signed 32-bit keys
// Insert, unique insert, index lookup, equal count, remove and fetch by
// position over up to CAPACITY keys kept in ascending order.
// ----------------------------------------------------------------------------
//  port group   direction  handshake           contents
//  s_*          in         s_valid / s_ready   func, key, position
//  m_*          out        m_valid / m_ready   status, value, found_index, entries
//  cfg_*        in         cfg_wr_en           reserved key
//
// One request is in work at a time. The key memory has one read port with a
// registered output, so each entry visited or moved takes a read state and then
// an evaluate or a write state.
// Reset clears the fill count and control; the key memory is not cleared.
// A new request is taken while the previous result waits in m_* for m_ready;
// a finished request holds in the result stage until m_* is free.
// ----------------------------------------------------------------------------
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY = SKT_CAPACITY
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_func,
    input  wire logic signed [31:0] s_key,
    input  wire logic [7:0]         s_position,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic signed [31:0]      m_value,
    output logic [8:0]              m_found_index,
    output logic [8:0]              m_entries,
    input  wire logic               cfg_wr_en,
    input  wire logic signed [31:0] cfg_wr_data
);

    skt_cmd_t  cmd;
    skt_stat_t st;

    skt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    skt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .s_func        (s_func),
        .s_key         (s_key),
        .s_position    (s_position),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_value       (m_value),
        .m_found_index (m_found_index),
        .m_entries     (m_entries)
    );

    // a result never reports more keys than the table holds
    a_entries_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entries <= 9'(CAPACITY)))
        else $error("entries above capacity");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid && !m_ready))
        else $error("result register overwritten");

    // the key memory only changes while a request is in work
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> !s_ready)
        else $error("memory write while idle");

    // one request at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while busy");

endmodule
`default_nettype wire

// ----- sv/skt_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skt_datapath: key memory, index/count registers and result register
// Holds the sorted keys in a single-port-read memory with registered read
// data, walks it under controller commands and keeps the result register.
// ----------------------------------------------------------------------------
module skt_datapath
    import skt_pkg::*;
#(
    parameter int CAPACITY = SKT_CAPACITY
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire skt_cmd_t           cmd,
    output skt_stat_t               st,
    input  wire logic [2:0]         s_func,
    input  wire logic signed [31:0] s_key,
    input  wire logic [7:0]         s_position,
    input  wire logic               cfg_wr_en,
    input  wire logic signed [31:0] cfg_wr_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic signed [31:0]      m_value,
    output logic [8:0]              m_found_index,
    output logic [8:0]              m_entries
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic signed [31:0] mem [CAPACITY];

    func_t              func_reg;
    logic signed [31:0] key_reg;
    logic [7:0]         pos_reg;
    logic signed [31:0] reserved_reg;
    logic [IW-1:0]      fill_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      mark_reg;
    logic [IW-1:0]      cnt_reg;
    logic               hit_reg;
    logic signed [31:0] rdata_reg;
    logic signed [31:0] fetch_reg;

    logic               m_valid_reg;
    logic               m_valid_next;
    logic [2:0]         m_status_reg;
    logic signed [31:0] m_value_reg;
    logic [8:0]         m_found_reg;
    logic [8:0]         m_entries_reg;

    logic [IW-1:0]      idx_below;
    logic [IW-1:0]      idx_above;
    logic [IW-1:0]      rd_idx;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic signed [31:0] res_value;
    logic [8:0]         res_found;

    assign idx_below = idx_reg - IW'(1);
    assign idx_above = idx_reg + IW'(1);

    // pick the read address
    always_comb begin
        case (cmd.rd_sel)
            RD_BELOW: rd_idx = idx_below;
            RD_ABOVE: rd_idx = idx_above;
            default:  rd_idx = idx_reg;
        endcase
    end

    assign wr_addr = idx_reg[AW-1:0];
    assign wr_data = cmd.wr_key ? key_reg : rdata_reg;

    // key memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    // capture the request
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            func_reg <= func_t'(s_func);
            key_reg  <= s_key;
            pos_reg  <= s_position;
        end
        if (cmd.fetch_load) begin
            fetch_reg <= rdata_reg;
        end
        if (cmd.mark_load) begin
            mark_reg <= idx_reg;
        end
    end

    // reserved key register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= SKT_RESERVED_RESET;
        end else if (cfg_wr_en) begin
            reserved_reg <= cfg_wr_data;
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.fill_inc) begin
            fill_reg <= fill_reg + IW'(1);
        end else if (cmd.fill_dec) begin
            fill_reg <= fill_reg - IW'(1);
        end
    end

    // walk index, equal count and hit flag
    always_ff @(posedge aclk) begin
        if (cmd.idx_clear) begin
            idx_reg <= '0;
        end else if (cmd.idx_load_pos) begin
            idx_reg <= IW'(pos_reg);
        end else if (cmd.idx_load_fill) begin
            idx_reg <= fill_reg;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_above;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_below;
        end

        if (cmd.cnt_clear) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + IW'(1);
        end

        if (cmd.hit_clear) begin
            hit_reg <= 1'b0;
        end else if (cmd.hit_load) begin
            hit_reg <= st.rd_equal;
        end
    end

    // status toward the controller
    always_comb begin
        st.func         = func_reg;
        st.key_reserved = (key_reg == reserved_reg);
        st.idx_at_fill  = (idx_reg == fill_reg);
        st.idx_at_mark  = (idx_reg == mark_reg);
        st.idx_last     = (idx_above == fill_reg);
        st.pos_in_range = (9'(pos_reg) < 9'(fill_reg));
        st.full         = (fill_reg == IW'(CAPACITY));
        st.rd_less      = (rdata_reg < key_reg);
        st.rd_equal     = (rdata_reg == key_reg);
        st.hit          = hit_reg;
        st.out_busy     = m_valid_reg && !m_ready;
    end

    // compose the result fields
    always_comb begin
        res_value = '0;
        res_found = '0;
        if (cmd.status != ST_OK) begin
            res_value = reserved_reg;
        end else begin
            case (func_reg)
                FN_REMOVE, FN_GET: res_value = fetch_reg;
                FN_INDEX_OF:       res_found = 9'(idx_reg);
                FN_COUNT:          res_found = 9'(cnt_reg);
                default:           res_value = '0;
            endcase
        end
    end

    assign m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.out_load) begin
            m_status_reg  <= cmd.status;
            m_value_reg   <= res_value;
            m_found_reg   <= res_found;
            m_entries_reg <= 9'(fill_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_value       = m_value_reg;
    assign m_found_index = m_found_reg;
    assign m_entries     = m_entries_reg;

endmodule
`default_nettype wire

// ----- sv/skt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skt_ctrl: request sequencer of the sorted key table
// Decodes one request, steps the datapath through the scan, shift, fetch and
// remove phases and chooses the result code.
// ----------------------------------------------------------------------------
module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire skt_stat_t st,
    output skt_cmd_t       cmd
);

    state_t  state_reg;
    state_t  state_next;
    status_t status_reg;
    status_t status_next;
    logic    is_insert;
    logic    shift_go;

    assign is_insert = (st.func == FN_INSERT) || (st.func == FN_INSERT_UNIQUE);
    assign shift_go  = is_insert && !st.full &&
                       !((st.func == FN_INSERT_UNIQUE) && st.hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // next state and result code
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (st.func)
                    FN_INSERT, FN_INSERT_UNIQUE: begin
                        if (st.key_reserved) begin
                            status_next = ST_RESERVED;
                            state_next  = S_RESP;
                        end else begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    FN_INDEX_OF, FN_COUNT: begin
                        state_next = S_SCAN_RD;
                    end
                    FN_REMOVE, FN_GET: begin
                        if (st.pos_in_range) begin
                            state_next = S_FETCH_RD;
                        end else begin
                            status_next = ST_RANGE;
                            state_next  = S_RESP;
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end
                endcase
            end
            S_SCAN_RD: begin
                state_next = st.idx_at_fill ? S_SCAN_END : S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (st.func == FN_COUNT || st.rd_less) begin
                    state_next = S_SCAN_RD;
                end else begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                state_next = S_RESP;
                if (st.func == FN_COUNT) begin
                    status_next = ST_OK;
                end else if (st.func == FN_INDEX_OF) begin
                    status_next = st.hit ? ST_OK : ST_MISS;
                end else if ((st.func == FN_INSERT_UNIQUE) && st.hit) begin
                    status_next = ST_MISS;
                end else if (st.full) begin
                    status_next = ST_FULL;
                end else begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                state_next = st.idx_at_mark ? S_PLACE : S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                state_next = S_SHIFT_RD;
            end
            S_PLACE: begin
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_FETCH_RD: begin
                state_next = S_FETCH_EV;
            end
            S_FETCH_EV: begin
                if (st.func == FN_REMOVE) begin
                    state_next = S_REM_RD;
                end else begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
            end
            S_REM_RD: begin
                if (st.idx_last) begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end else begin
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR: begin
                state_next = S_REM_RD;
            end
            S_RESP: begin
                if (!st.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        cmd        = '0;
        cmd.status = status_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            S_DECODE: begin
                cmd.cnt_clear = 1'b1;
                cmd.hit_clear = 1'b1;
                if (st.func == FN_REMOVE || st.func == FN_GET) begin
                    cmd.idx_load_pos = 1'b1;
                end else begin
                    cmd.idx_clear = 1'b1;
                end
            end
            S_SCAN_RD: begin
                cmd.rd_en  = !st.idx_at_fill;
                cmd.rd_sel = RD_AT_IDX;
            end
            S_SCAN_EV: begin
                if (st.func == FN_COUNT) begin
                    cmd.cnt_inc = st.rd_equal;
                    cmd.idx_inc = 1'b1;
                end else if (st.rd_less) begin
                    cmd.idx_inc = 1'b1;
                end else begin
                    cmd.hit_load = 1'b1;
                end
            end
            S_SCAN_END: begin
                // remember the insert point and start shifting from the top
                cmd.mark_load     = shift_go;
                cmd.idx_load_fill = shift_go;
            end
            S_SHIFT_RD: begin
                cmd.rd_en  = !st.idx_at_mark;
                cmd.rd_sel = RD_BELOW;
            end
            S_SHIFT_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.idx_dec = 1'b1;
            end
            S_PLACE: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_key   = 1'b1;
                cmd.fill_inc = 1'b1;
            end
            S_FETCH_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT_IDX;
            end
            S_FETCH_EV: begin
                cmd.fetch_load = 1'b1;
            end
            S_REM_RD: begin
                if (st.idx_last) begin
                    cmd.fill_dec = 1'b1;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ABOVE;
                end
            end
            S_REM_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_RESP: begin
                cmd.out_load = !st.out_busy;
            end
            default: begin
                cmd.status = status_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- tb/sv/sorted_key_table_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_test: self-checking bench for the sorted key table
// Drives insert, unique insert, lookup, count, remove and fetch requests with
// random idling on both handshakes and compares every result, field by field,
// against an in-bench model of the ordered table. Runs a directed pass, random
// passes under several reserved-key settings, then a back-to-back stream.
// ----------------------------------------------------------------------------
module sorted_key_table_test
    import skt_pkg::*;
();

    localparam int CAPACITY = SKT_CAPACITY;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
    // request codes outside the defined set; the block answers them as no-ops
    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;

    typedef struct {
        logic [2:0]         status;
        logic signed [31:0] value;
        logic [8:0]         found_index;
        logic [8:0]         entries;
    } table_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_func = FN_INSERT;
    logic signed [31:0] s_key = '0;
    logic [7:0]         s_position = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_status;
    logic signed [31:0] m_value;
    logic [8:0]         m_found_index;
    logic [8:0]         m_entries;
    logic               cfg_wr_en = 1'b0;
    logic signed [31:0] cfg_wr_data = '0;

    // model of the table contents and the reserved-key register
    logic signed [31:0] held_keys [CAPACITY];
    int                 held_count = 0;
    logic signed [31:0] sentinel_key = SKT_RESERVED_RESET;

    table_result_t      pending_results [$];
    logic signed [31:0] key_pool [8];
    int                 mismatches = 0;
    int                 requests_sent = 0;
    int                 settings_used = 1;
    int                 status_seen [5] = '{default: 0};
    int                 cycle_count = 0;
    int                 stall_left = 0;
    bit                 calm = 1'b0;
    bit                 valid_up = 1'b0;

    sorted_key_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_key        (s_key),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_value      (m_value),
        .m_found_index(m_found_index),
        .m_entries    (m_entries),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // apply one request to the model table and return the result it gives
    function automatic table_result_t apply_request(input logic [2:0] fn,
                                                    input logic signed [31:0] k,
                                                    input logic [7:0] p);
        table_result_t r;
        int at;
        int hits;
        int i;
        r.status = ST_OK;
        r.value = '0;
        r.found_index = '0;
        at = 0;
        while (at < held_count && held_keys[at] < k) at++;
        case (fn)
            FN_INSERT, FN_INSERT_UNIQUE: begin
                if (k == sentinel_key) begin
                    r.status = ST_RESERVED;
                end else if (fn == FN_INSERT_UNIQUE && at < held_count &&
                             held_keys[at] == k) begin
                    r.status = ST_MISS;
                end else if (held_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = held_count; i > at; i--) held_keys[i] = held_keys[i - 1];
                    held_keys[at] = k;
                    held_count++;
                end
            end
            FN_INDEX_OF: begin
                if (at < held_count && held_keys[at] == k)
                    r.found_index = 9'(at);
                else
                    r.status = ST_MISS;
            end
            FN_COUNT: begin
                hits = 0;
                for (i = 0; i < held_count; i++)
                    if (held_keys[i] == k) hits++;
                r.found_index = 9'(hits);
            end
            FN_REMOVE, FN_GET: begin
                if (int'(p) >= held_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.value = held_keys[p];
                    if (fn == FN_REMOVE) begin
                        for (i = int'(p); i + 1 < held_count; i++)
                            held_keys[i] = held_keys[i + 1];
                        held_count--;
                    end
                end
            end
            default: ;
        endcase
        if (r.status != ST_OK) r.value = sentinel_key;
        r.entries = 9'(held_count);
        status_seen[r.status]++;
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // compare each accepted result with the oldest expectation; pace m_ready
    always @(posedge aclk) begin
        table_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d value %0d", m_status, m_value);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_status);
                check_field("value", want.value, m_value);
                check_field("found_index", want.found_index, m_found_index);
                check_field("entries", want.entries, m_entries);
            end
        end
        if (calm) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // send one request, optionally after an idle burst, and log its result
    task automatic send_request(input logic [2:0] fn, input logic signed [31:0] k,
                                input logic [7:0] p);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            if (valid_up) s_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        valid_up = 1'b1;
        s_func <= fn;
        s_key <= k;
        s_position <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_request(fn, k, p));
        requests_sent++;
    endtask

    // drop valid and hold until every outstanding result has come back
    task automatic wait_for_results();
        if (valid_up) s_valid <= 1'b0;
        valid_up = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // write the reserved key; only called with the block idle
    task automatic set_reserved_key(input logic signed [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        sentinel_key = v;
        settings_used++;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return key_pool[$urandom_range(0, 7)];
        if (roll < 7 && held_count > 0) return held_keys[$urandom_range(0, held_count - 1)];
        return $urandom;
    endfunction

    task automatic load_key_pool();
        int i;
        key_pool[0] = sentinel_key;
        key_pool[1] = KEY_MIN;
        key_pool[2] = KEY_MAX;
        key_pool[3] = '0;
        key_pool[4] = -32'sd1;
        for (i = 5; i < 8; i++) key_pool[i] = $signed($urandom_range(0, 20)) - 10;
    endtask

    function automatic logic [2:0] pick_func(input int insert_share, input int remove_share);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < insert_share)
            return $urandom_range(0, 1) ? FN_INSERT_UNIQUE : FN_INSERT;
        if (roll < insert_share + remove_share) return FN_REMOVE;
        if (roll < 97) begin
            case ($urandom_range(0, 2))
                0: return FN_INDEX_OF;
                1: return FN_COUNT;
                default: return FN_GET;
            endcase
        end
        return $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
    endfunction

    // empty-table errors, ordering, duplicates, reserved-key rules, spare codes
    task automatic test_directed_cases();
        send_request(FN_GET, 32'sd0, 8'd0);
        send_request(FN_REMOVE, 32'sd0, 8'd255);
        send_request(FN_INDEX_OF, 32'sd0, 8'd0);
        send_request(FN_COUNT, 32'sd0, 8'd0);
        send_request(FN_INSERT, KEY_MIN, 8'd0);
        send_request(FN_INSERT_UNIQUE, KEY_MIN, 8'd0);
        send_request(FN_INSERT, KEY_MAX, 8'd0);
        send_request(FN_INSERT, KEY_MIN + 1, 8'd0);
        send_request(FN_INSERT, 32'sd0, 8'd0);
        send_request(FN_INSERT, 32'sd0, 8'd0);
        send_request(FN_INSERT_UNIQUE, 32'sd0, 8'd0);
        send_request(FN_INSERT_UNIQUE, -32'sd1, 8'd0);
        send_request(FN_INDEX_OF, 32'sd0, 8'd0);
        send_request(FN_COUNT, 32'sd0, 8'd0);
        send_request(FN_INDEX_OF, KEY_MAX, 8'd0);
        send_request(FN_GET, 32'sd0, 8'd4);
        send_request(FN_GET, 32'sd0, 8'd5);
        send_request(FN_REMOVE, 32'sd0, 8'd0);
        send_request(FN_SPARE_A, 32'sh5a5a_a5a5, 8'd170);
        send_request(FN_SPARE_B, -32'sd1, 8'd255);
        send_request(FN_COUNT, KEY_MIN, 8'd0);
        // stored keys equal to the reserved key are still searchable
        wait_for_results();
        set_reserved_key(32'sd0);
        send_request(FN_COUNT, 32'sd0, 8'd0);
        send_request(FN_INDEX_OF, 32'sd0, 8'd0);
        send_request(FN_INSERT, 32'sd0, 8'd0);
        send_request(FN_REMOVE, 32'sd0, 8'd3);
        wait_for_results();
        set_reserved_key(KEY_MAX);
        send_request(FN_INSERT, KEY_MIN, 8'd0);
        send_request(FN_GET, 32'sd0, 8'd0);
        wait_for_results();
    endtask

    // random traffic that swings between filling and draining the table
    task automatic test_random_traffic(input logic signed [31:0] reserved, input int count);
        int n;
        int insert_share;
        int remove_share;
        logic [2:0] fn;
        logic [7:0] pos;
        wait_for_results();
        set_reserved_key(reserved);
        load_key_pool();
        insert_share = 15;
        remove_share = 40;
        for (n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                insert_share = (insert_share == 15) ? 55 : 15;
                remove_share = (insert_share == 15) ? 40 : 20;
            end
            if ($urandom_range(0, 99) == 0) wait_for_results();
            fn = pick_func(insert_share, remove_share);
            if ($urandom_range(0, 7) == 0)
                pos = 8'($urandom_range(0, 255));
            else
                pos = 8'($urandom_range(0, held_count));
            send_request(fn, pick_key(), pos);
        end
    endtask

    // back-to-back requests with no idling on either side
    task automatic test_streaming(input int count);
        int n;
        wait_for_results();
        calm = 1'b1;
        load_key_pool();
        for (n = 0; n < count; n++)
            send_request(pick_func(held_count < CAPACITY / 2 ? 50 : 20, 30), pick_key(),
                         8'($urandom_range(0, held_count)));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_traffic(KEY_MIN, 280);
        test_random_traffic(KEY_MAX, 280);
        test_random_traffic(32'sd0, 280);
        test_random_traffic(-32'sd1, 280);
        test_random_traffic($urandom, 280);
        test_streaming(200);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        $display("Ran %0d requests under %0d reserved-key settings, with and without idling.",
                 requests_sent, settings_used);
        $display("Results: %0d ok, %0d miss/duplicate, %0d range, %0d full, %0d reserved key.",
                 status_seen[ST_OK], status_seen[ST_MISS], status_seen[ST_RANGE],
                 status_seen[ST_FULL], status_seen[ST_RESERVED]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
